// ===== hdl/pbra_pkg.sv =====
package pbra_pkg;

   // Bitmap word geometry: one memory word holds the used bits of 64 pages.
   localparam int WORD_SHIFT = 6;
   localparam int WORD_W     = 1 << WORD_SHIFT;

   // Fixed field widths of the request and response channels.
   localparam int TYPE_W       = 2;
   localparam int PAGE_FIELD_W = 12;
   localparam int COUNT_W      = 13;

   // A partial run carried between words stays below the requested count,
   // so one bit above the count width covers the count plus one word.
   localparam int RUN_W = COUNT_W + 1;

   localparam int NUM_PAGES_DEF      = 4096;
   localparam int RESERVED_PAGES_DEF = 16;

   // Response status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_RUN = 1'b1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FIXED = 2'd1,
      REQ_FREE  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } pbra_state_type;

   typedef struct packed {
      logic                  hit;
      logic                  carry_hit;
      logic [WORD_SHIFT-1:0] pos;
      logic [RUN_W-1:0]      run_out;
   } scan_res_type;

endpackage

// ===== hdl/pbra_if.sv =====
interface pbra_req_if
   import pbra_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic [PAGE_FIELD_W-1:0] start_page;
   logic [COUNT_W-1:0]      page_count;

   modport source (output valid, output req_type, output start_page, output page_count,
                   input ready);
   modport sink   (input valid, input req_type, input start_page, input page_count,
                   output ready);
endinterface

interface pbra_rsp_if
   import pbra_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic                    status;
   logic [PAGE_FIELD_W-1:0] result_page;

   modport source (output valid, output status, output result_page, input ready);
   modport sink   (input valid, input status, input result_page, output ready);
endinterface

// ===== hdl/pbra_ram.sv =====
module pbra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/pbra_word_scan.sv =====
module pbra_word_scan
   import pbra_pkg::*;
(
   input  logic [WORD_W-1:0]     used_word,
   input  logic [WORD_SHIFT-1:0] first_bit,
   input  logic [RUN_W-1:0]      carry_run,
   input  logic [COUNT_W-1:0]    count,
   output scan_res_type          res
);
   localparam int LEN_W = WORD_SHIFT + 1;
   localparam int SUM_W = RUN_W + 1;

   logic [WORD_W-1:0]     free_bits;
   logic                  all_free;
   logic [WORD_SHIFT-1:0] low_used;
   logic [WORD_SHIFT-1:0] high_used;
   logic [WORD_SHIFT-1:0] tail_len;
   logic [LEN_W-1:0]      head_len;
   logic [SUM_W-1:0]      head_sum;
   logic                  carry_hit;
   logic [WORD_W-1:0]     grow [WORD_SHIFT+1];
   logic [WORD_W-1:0]     win;
   logic                  win_started;
   logic                  short_run;
   logic [WORD_SHIFT-1:0] win_pos;

   always_comb begin
      // Pages below the search start count as used.
      free_bits = ~used_word & ({WORD_W{1'b1}} << first_bit);
      all_free  = &free_bits;

      low_used  = '0;
      high_used = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!free_bits[i]) low_used = WORD_SHIFT'(i);
      end
      for (int i = 0; i < WORD_W; i++) begin
         if (!free_bits[i]) high_used = WORD_SHIFT'(i);
      end
      // Free pages above the highest used page.
      tail_len = ~high_used;

      // Run that started in earlier words and continues from bit 0.
      head_len  = all_free ? LEN_W'(WORD_W) : {1'b0, low_used};
      head_sum  = {1'b0, carry_run} + SUM_W'(head_len);
      carry_hit = head_sum >= SUM_W'(count);

      // grow[k] marks bits that open a free window of 2**k pages.
      grow[0] = free_bits;
      for (int k = 0; k < WORD_SHIFT; k++) begin
         grow[k+1] = grow[k] & (grow[k] >> (1 << k));
      end

      // Chain the power-of-two windows into one window of count pages.
      win         = '0;
      win_started = 1'b0;
      for (int k = 0; k < WORD_SHIFT; k++) begin
         if (count[k]) begin
            win         = win_started ? (grow[k] & (win >> (1 << k))) : grow[k];
            win_started = 1'b1;
         end
      end
      short_run = (count >> WORD_SHIFT) == '0;

      win_pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (win[i]) win_pos = WORD_SHIFT'(i);
      end

      res.hit       = carry_hit || (short_run && (|win));
      res.carry_hit = carry_hit;
      res.pos       = win_pos;
      res.run_out   = all_free ? (carry_run + RUN_W'(WORD_W)) : RUN_W'(tail_len);
   end
endmodule

// ===== hdl/page_bitmap_range_allocator_core.sv =====
// Next-fit page allocator over a used-page bitmap kept in one on-chip memory of
// 64-bit words. A request is either allocate (find page_count free pages from the
// search hint, wrapping once to the first unreserved page), fixed (mark a range
// used) or free (mark a range free); each request gets exactly one response with
// status 0 on success and the start page, or status 1 and page 0 on failure.
// Ranges running past the end of the map are clipped. After reset the block
// sweeps the bitmap once, one word per cycle, over all ceil(NUM_PAGES/64) words
// (64 for the default map), with req_chan.ready low. Requests are handled one at
// a time: an allocate reads bitmap words from the hint onward (up to about twice
// the word count when the search wraps), then reads and rewrites each word of the
// found run; fixed and free read and rewrite each word touched.
// The single read port of the bitmap memory sets the pace of scanning and
// marking. A finished response waits in an output register, so the next request
// is taken while it is held.
module page_bitmap_range_allocator_core
   import pbra_pkg::*;
#(
   parameter int NUM_PAGES      = NUM_PAGES_DEF,
   parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pbra_req_if.sink   req_chan,
   pbra_rsp_if.source rsp_chan
);
   localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   // Page numbers and the hint, which may sit one past the last page.
   localparam int PG_W      = $clog2(NUM_PAGES + 1);
   localparam int CALC_W    = ((PG_W > COUNT_W) ? PG_W : COUNT_W) + 1;
   localparam int RSV       = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;

   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
   localparam logic [WADDR_W-1:0] RSV_WORD  = WADDR_W'(RSV / WORD_W);
   localparam logic [CALC_W-1:0]  NUM_C     = CALC_W'(NUM_PAGES);
   localparam logic [CALC_W-1:0]  RSV_C     = CALC_W'(RSV);

   // Control state.
   pbra_state_type      state_ff, state_in;
   logic [WADDR_W-1:0]  clr_word_ff, clr_word_in;
   logic [PG_W-1:0]     hint_ff, hint_in;
   logic [WADDR_W-1:0]  issue_word_ff, issue_word_in;
   logic                issue_done_ff, issue_done_in;
   logic                rdv_ff, rdv_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   logic [WADDR_W-1:0]      last_word_ff, last_word_in;
   logic [WADDR_W-1:0]      rd_word_ff, rd_word_in;
   logic [PG_W-1:0]         from_ff, from_in;
   logic                    pass2_ff, pass2_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [PG_W-1:0]         lo_ff, lo_in;
   logic [PG_W-1:0]         last_pg_ff, last_pg_in;
   logic                    op_set_ff, op_set_in;
   logic                    res_status_ff, res_status_in;
   logic [PAGE_FIELD_W-1:0] res_page_ff, res_page_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [PAGE_FIELD_W-1:0] rsp_page_ff, rsp_page_in;

   // Datapath.
   logic                    issue_en;
   logic                    ram_wr_en;
   logic [WADDR_W-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]       ram_wr_data;
   logic [WORD_W-1:0]       ram_rd_data;
   logic [WORD_SHIFT-1:0]   scan_first_bit;
   scan_res_type            scan_res;
   logic [CALC_W-1:0]       base_c;
   logic [CALC_W-1:0]       found_c;
   logic [CALC_W-1:0]       found_end_c;
   logic [CALC_W-1:0]       hint_c;
   logic [CALC_W-1:0]       req_start_c;
   logic [CALC_W-1:0]       req_count_c;
   logic [CALC_W-1:0]       req_end_raw;
   logic [CALC_W-1:0]       req_end_c;
   logic [WORD_SHIFT-1:0]   lo_bit;
   logic [WORD_SHIFT-1:0]   hi_bit;
   logic [WORD_W-1:0]       mark_mask;
   logic [WORD_W-1:0]       clear_word;

   pbra_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue_en),
      .rd_addr (issue_word_ff),
      .rd_data (ram_rd_data)
   );

   // Mask pages below the scan start in the first word of a pass.
   assign scan_first_bit = (rd_word_ff == WADDR_W'(from_ff >> WORD_SHIFT)) ?
                           WORD_SHIFT'(from_ff) : '0;

   pbra_word_scan u_scan (
      .used_word (ram_rd_data),
      .first_bit (scan_first_bit),
      .carry_run (run_ff),
      .count     (count_ff),
      .res       (scan_res)
   );

   // Start page of a hit: a run carried in from earlier words starts before
   // this word, a run inside the word starts at the window position.
   assign base_c      = CALC_W'(rd_word_ff) << WORD_SHIFT;
   assign found_c     = scan_res.carry_hit ? (base_c - CALC_W'(run_ff)) :
                                             (base_c + CALC_W'(scan_res.pos));
   assign found_end_c = found_c + CALC_W'(count_ff);
   assign hint_c      = CALC_W'(hint_ff);

   // Fixed or free range, clipped to the map.
   assign req_start_c = CALC_W'(req_chan.start_page);
   assign req_count_c = CALC_W'(req_chan.page_count);
   assign req_end_raw = req_start_c + req_count_c;
   assign req_end_c   = (req_end_raw > NUM_C) ? NUM_C : req_end_raw;

   // Bits of the current word covered by the range being marked.
   assign lo_bit    = (rd_word_ff == WADDR_W'(lo_ff >> WORD_SHIFT)) ? WORD_SHIFT'(lo_ff) : '0;
   assign hi_bit    = (rd_word_ff == last_word_ff) ? WORD_SHIFT'(last_pg_ff) : '1;
   assign mark_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));

   // Reset image of one word: reserved pages and pages past the map end are used.
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         clear_word[j] = (((CALC_W'(clr_word_ff) << WORD_SHIFT) + CALC_W'(j)) < RSV_C) ||
                         (((CALC_W'(clr_word_ff) << WORD_SHIFT) + CALC_W'(j)) >= NUM_C);
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.result_page = rsp_page_ff;

   always_comb begin
      state_in      = state_ff;
      clr_word_in   = clr_word_ff;
      hint_in       = hint_ff;
      issue_word_in = issue_word_ff;
      issue_done_in = issue_done_ff;
      last_word_in  = last_word_ff;
      rd_word_in    = rd_word_ff;
      from_in       = from_ff;
      pass2_in      = pass2_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      lo_in         = lo_ff;
      last_pg_in    = last_pg_ff;
      op_set_in     = op_set_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_word_ff;
      ram_wr_data   = '0;

      // Stream reads one word per cycle; stop issuing once a scan hits so no
      // stale word is in flight when the mark phase starts.
      issue_en = ((state_ff == ST_SCAN && !(rdv_ff && scan_res.hit)) ||
                  state_ff == ST_MARK) && !issue_done_ff;
      rdv_in = issue_en;
      if (issue_en) begin
         rd_word_in = issue_word_ff;
         if (issue_word_ff == last_word_ff) begin
            issue_done_in = 1'b1;
         end else begin
            issue_word_in = issue_word_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_word_ff;
            ram_wr_data = clear_word;
            if (clr_word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_word_in = clr_word_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_chan.valid) begin
               // Default to failure; success paths overwrite.
               res_status_in = STATUS_NO_RUN;
               res_page_in   = '0;
               state_in      = ST_DONE;
               unique case (req_kind_type'(req_chan.req_type))
                  REQ_ALLOC: begin
                     count_in     = req_chan.page_count;
                     run_in       = '0;
                     last_word_in = LAST_WORD;
                     if (req_count_c == '0 || req_count_c > NUM_C) begin
                        state_in = ST_DONE;
                     end else if (hint_c < NUM_C) begin
                        // First pass: from the hint to the end of the map.
                        from_in       = hint_ff;
                        pass2_in      = 1'b0;
                        issue_word_in = WADDR_W'(hint_ff >> WORD_SHIFT);
                        issue_done_in = 1'b0;
                        state_in      = ST_SCAN;
                     end else if (RSV_C < NUM_C) begin
                        // Hint at the map end: wrap at once.
                        from_in       = PG_W'(RSV_C);
                        pass2_in      = 1'b1;
                        issue_word_in = RSV_WORD;
                        issue_done_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  REQ_FIXED, REQ_FREE: begin
                     res_status_in = STATUS_OK;
                     res_page_in   = req_chan.start_page;
                     op_set_in     = (req_kind_type'(req_chan.req_type) == REQ_FIXED);
                     if (req_count_c != '0 && req_start_c < NUM_C) begin
                        lo_in         = PG_W'(req_start_c);
                        last_pg_in    = PG_W'(req_end_c - 1'b1);
                        issue_word_in = WADDR_W'(req_start_c >> WORD_SHIFT);
                        last_word_in  = WADDR_W'((req_end_c - 1'b1) >> WORD_SHIFT);
                        issue_done_in = 1'b0;
                        state_in      = ST_MARK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (rdv_ff) begin
               priority if (scan_res.hit) begin
                  if (pass2_ff && found_c > hint_c) begin
                     // Wrapped run lies above the hint: reject.
                     res_status_in = STATUS_NO_RUN;
                     res_page_in   = '0;
                     state_in      = ST_DONE;
                  end else begin
                     res_status_in = STATUS_OK;
                     res_page_in   = PAGE_FIELD_W'(found_c);
                     hint_in       = PG_W'(found_end_c);
                     op_set_in     = 1'b1;
                     lo_in         = PG_W'(found_c);
                     last_pg_in    = PG_W'(found_end_c - 1'b1);
                     issue_word_in = WADDR_W'(found_c >> WORD_SHIFT);
                     last_word_in  = WADDR_W'((found_end_c - 1'b1) >> WORD_SHIFT);
                     issue_done_in = 1'b0;
                     state_in      = ST_MARK;
                  end
               end else if (rd_word_ff == LAST_WORD) begin
                  if (!pass2_ff && RSV_C < NUM_C) begin
                     // End of the first pass: wrap to the first unreserved page.
                     from_in       = PG_W'(RSV_C);
                     pass2_in      = 1'b1;
                     run_in        = '0;
                     issue_word_in = RSV_WORD;
                     issue_done_in = 1'b0;
                  end else begin
                     res_status_in = STATUS_NO_RUN;
                     res_page_in   = '0;
                     state_in      = ST_DONE;
                  end
               end else begin
                  run_in = scan_res.run_out;
               end
            end
         end

         ST_MARK: begin
            if (rdv_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_word_ff;
               ram_wr_data = op_set_ff ? (ram_rd_data | mark_mask) :
                                         (ram_rd_data & ~mark_mask);
               if (rd_word_ff == last_word_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_word_ff   <= '0;
         hint_ff       <= PG_W'(RSV_C);
         issue_word_ff <= '0;
         issue_done_ff <= 1'b1;
         rdv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_word_ff   <= clr_word_in;
         hint_ff       <= hint_in;
         issue_word_ff <= issue_word_in;
         issue_done_ff <= issue_done_in;
         rdv_ff        <= rdv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_word_ff  <= last_word_in;
      rd_word_ff    <= rd_word_in;
      from_ff       <= from_in;
      pass2_ff      <= pass2_in;
      count_ff      <= count_in;
      run_ff        <= run_in;
      lo_ff         <= lo_in;
      last_pg_ff    <= last_pg_in;
      op_set_ff     <= op_set_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end
endmodule

// ===== hdl/pbra_checker.sv =====
module pbra_checker
   import pbra_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_status,
   input logic [PAGE_FIELD_W-1:0] rsp_page
);
   logic [1:0] outst_ff, outst_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outst_in = outst_ff;
      if (req_fire && !rsp_fire) begin
         outst_in = outst_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         outst_in = outst_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // The bitmap sweep follows reset: no request taken, no response shown.
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("request port open or response shown right after reset");

   // A response always answers an earlier request.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("response without an outstanding request");

   // At most one finished response may wait when a new request is taken.
   a_request_depth: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> outst_ff <= 2'd1)
      else $error("request taken with too many requests outstanding");

   // A failed request reports page zero.
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_RUN |-> rsp_page == '0)
      else $error("failure response with nonzero page");
endmodule

bind page_bitmap_range_allocator_core pbra_checker u_pbra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_page   (rsp_chan.result_page)
);
